/* hw/rtl/icw_pkg.sv */
// Package for the coherence window block: sizes, register map, column sum layout
// and the histogram helper. No dependencies.
package icw_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int CROSS_BITS       = 2 * SAMPLE_BITS + 6;
	localparam int POWER_BITS       = 2 * SAMPLE_BITS + 5;
	localparam int DEF_MAX_COLS     = 4096;
	localparam int DEF_MAX_WIN_COLS = 16;
	localparam int LINE_WIDTH_BITS  = 13;
	localparam int WIN_REG_BITS     = 5;
	localparam int COH_BITS         = 16;
	localparam int COL_OUT_BITS     = 12;
	localparam int BIN_BITS         = 4;
	localparam int ONE_Q15          = 32768;
	localparam int HIST_BINS        = 10;
	localparam int ADDR_BITS        = 4;
	localparam int DATA_BITS        = 32;

	localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RST  = 13'd4096;
	localparam logic [WIN_REG_BITS-1:0]    WINDOW_COLS_RST = 5'd3;
	localparam logic [WIN_REG_BITS-1:0]    COL_STEP_RST    = 5'd1;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH  = 2'd0,
		REG_WINDOW_COLS = 2'd1,
		REG_COL_STEP    = 2'd2
	} reg_idx_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [CROSS_BITS-1:0] cross_re;
		logic [CROSS_BITS-1:0] cross_im;
		logic [POWER_BITS-1:0] pow_a;
		logic [POWER_BITS-1:0] pow_b;
	} col_sums_t;

	localparam int COL_SUMS_BITS = $bits(col_sums_t);

	// tenths bin of a Q1.15 coherence, clamped to the top bin
	function automatic logic [BIN_BITS-1:0] hist_of(input logic [COH_BITS-1:0] coh);
		logic [COH_BITS+4:0] t;
		logic [5:0]          b;
		t = (COH_BITS+5)'(coh) * (COH_BITS+5)'(HIST_BINS);
		b = t[COH_BITS+4:COH_BITS-1];
		hist_of = (b > 6'(HIST_BINS - 1)) ? BIN_BITS'(HIST_BINS - 1) : b[BIN_BITS-1:0];
	endfunction

endpackage

/* hw/rtl/icw_if.sv */
// Stream interfaces of the coherence window block: pixel pairs in, results out.
// Depends on icw_pkg.
interface icw_in_if;
	import icw_pkg::*;
	logic    valid;
	logic    ready;
	sample_t a_re;
	sample_t a_im;
	sample_t b_re;
	sample_t b_im;
	logic    first_row;
	logic    last_row;
	modport source(output valid, a_re, a_im, b_re, b_im, first_row, last_row, input ready);
	modport sink(input valid, a_re, a_im, b_re, b_im, first_row, last_row, output ready);
endinterface

interface icw_out_if;
	import icw_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [COH_BITS-1:0]     coherence;
	logic [COL_OUT_BITS-1:0] out_col;
	logic [BIN_BITS-1:0]     hist_bin;
	logic                    line_done;
	modport source(output valid, coherence, out_col, hist_bin, line_done, input ready);
	modport sink(input valid, coherence, out_col, hist_bin, line_done, output ready);
endinterface

/* hw/rtl/interferometric_coherence_window.sv */
// Top level of the boxcar coherence estimator: register port, column sum RAM
// with read-modify-write, window sequencer. Uses icw_pkg, icw_if, icw_ram, icw_coh.
//
//  channel  | dir | handshake      | beat
//  ---------+-----+----------------+-------------------------------------------
//  in_ch    | in  | valid/ready    | a_re a_im b_re b_im first_row last_row
//  out_ch   | out | valid/ready    | coherence out_col hist_bin line_done
//  apb      | in  | psel/penable   | paddr pwdata (regs at 0x0, 0x4, 0x8)
//
// One pixel beat at a time; a beat that closes no window passes accept, products and
// the column RMW through the registered RAM read. A beat that may close windows adds
// a serial start/step division, then per window a pass over the cached column sums
// and the coherence unit (12 multiply steps, a zero check, 16 root steps). Output is
// one register deep; a stalled sink holds the next window. Reset clears control only;
// column sums are valid once a row flagged first_row has been written.
module interferometric_coherence_window #(
	parameter int MAX_COLS     = icw_pkg::DEF_MAX_COLS,
	parameter int MAX_WIN_COLS = icw_pkg::DEF_MAX_WIN_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [icw_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [icw_pkg::DATA_BITS-1:0]  pwdata,
	output logic [icw_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	icw_in_if.sink                         in_ch,
	icw_out_if.source                      out_ch
);
	import icw_pkg::*;

	localparam int CW  = $clog2(MAX_COLS);
	localparam int NW  = CW + 1;
	localparam int WW  = $clog2(MAX_WIN_COLS + 1);
	localparam int TW  = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
	localparam int CSW = CROSS_BITS + WW;
	localparam int PSW = POWER_BITS + WW;
	localparam int OW  = CSW;
	localparam int DCW = $clog2(CW + 1);
	localparam int PRB = 2 * SAMPLE_BITS + 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PROD  = 8'b0000_0010,
		ST_UPD   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_SUM   = 8'b0001_0000,
		ST_START = 8'b0010_0000,
		ST_COH   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	// configuration
	logic [LINE_WIDTH_BITS-1:0] lw_q;
	logic [WIN_REG_BITS-1:0]    wc_q, cs_q;
	reg_idx_t                   ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LINE_WIDTH_RST;
			wc_q <= WINDOW_COLS_RST;
			cs_q <= COL_STEP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_LINE_WIDTH:  lw_q <= pwdata[LINE_WIDTH_BITS-1:0];
				REG_WINDOW_COLS: wc_q <= pwdata[WIN_REG_BITS-1:0];
				REG_COL_STEP:    cs_q <= pwdata[WIN_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_LINE_WIDTH:  prdata = DATA_BITS'(lw_q);
			REG_WINDOW_COLS: prdata = DATA_BITS'(wc_q);
			REG_COL_STEP:    prdata = DATA_BITS'(cs_q);
			default:         prdata = '0;
		endcase
	end

	// effective register values
	logic [31:0]   lw32, wc32, cs32;
	logic [NW-1:0] ns;
	logic [WW-1:0] ws, st;

	always_comb begin
		lw32 = 32'(lw_q);
		wc32 = 32'(wc_q);
		cs32 = 32'(cs_q);
		ns = (lw32 == 0) ? NW'(1) : (lw32 > 32'(MAX_COLS)) ? NW'(MAX_COLS) : lw32[NW-1:0];
		ws = (wc32 == 0) ? WW'(1) :
			(wc32 > 32'(MAX_WIN_COLS)) ? WW'(MAX_WIN_COLS) : wc32[WW-1:0];
		st = (cs32 == 0) ? WW'(1) :
			(cs32 > 32'(MAX_WIN_COLS)) ? WW'(MAX_WIN_COLS) : cs32[WW-1:0];
	end

	state_t         state_q;
	logic [CW-1:0]  pos_q, col_q, c_now;
	sample_t        ar_q, ai_q, br_q, bi_q;
	logic           first_q, last_q, end_q, mid_q;
	logic signed [PRB-1:0] xr_q, xi_q;
	logic [PRB-1:0] pa_q, pb_q;

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign c_now       = ({1'b0, pos_q} >= ns) ? '0 : pos_q;

	// products of the latched pixel pair
	logic signed [2*SAMPLE_BITS-1:0] p_rr, p_ii, p_ir, p_ri, p_aa, p_bb;
	always_comb begin
		p_rr = ar_q * br_q;
		p_ii = ai_q * bi_q;
		p_ir = ai_q * br_q;
		p_ri = ar_q * bi_q;
		p_aa = ar_q * ar_q + ai_q * ai_q;
		p_bb = br_q * br_q + bi_q * bi_q;
	end

	// column sum memory
	logic [COL_SUMS_BITS-1:0] ram_rdata;
	col_sums_t                rd, upd;
	assign rd = col_sums_t'(ram_rdata);

	always_comb begin
		if (first_q) begin
			upd.cross_re = CROSS_BITS'(xr_q);
			upd.cross_im = CROSS_BITS'(xi_q);
			upd.pow_a    = POWER_BITS'(pa_q);
			upd.pow_b    = POWER_BITS'(pb_q);
		end else begin
			upd.cross_re = rd.cross_re + CROSS_BITS'(xr_q);
			upd.cross_im = rd.cross_im + CROSS_BITS'(xi_q);
			upd.pow_a    = rd.pow_a + POWER_BITS'(pa_q);
			upd.pow_b    = rd.pow_b + POWER_BITS'(pb_q);
		end
	end

	icw_ram #(
		.WIDTH(COL_SUMS_BITS),
		.DEPTH(MAX_COLS)
	) u_cols (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(col_q),
		.wdata(upd),
		.re   (in_acc),
		.raddr(c_now),
		.rdata(ram_rdata)
	);

	// the latest columns' sums, newest at tap 0
	col_sums_t taps_q [MAX_WIN_COLS];

	// window decision
	logic [31:0]   col32, ns32, ws32;
	logic          is_end, is_mid;
	logic [CW-1:0] v_end, v_mid;
	always_comb begin
		col32  = 32'(col_q);
		ns32   = 32'(ns);
		ws32   = 32'(ws);
		is_end = last_q && (col32 == ns32 - 1);
		is_mid = last_q && !is_end && (col32 + 1 >= ws32);
		v_end  = (ns32 > ws32) ? CW'(ns32 - ws32) : '0;
		v_mid  = CW'(col32 + 1 - ws32);
	end

	// serial divider by col_step
	logic [CW-1:0]  v_q, dq_q;
	logic [WW-1:0]  rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [WW:0]    r2;
	logic           ge;
	logic           rnz;
	logic [NW-1:0]  s_next;
	logic [CW-1:0]  wcol_next;
	always_comb begin
		r2        = {rem_q, dq_q[CW-1]};
		ge        = r2 >= {1'b0, st};
		rnz       = rem_q != '0;
		s_next    = {1'b0, v_q} + (rnz ? NW'(st - rem_q) : NW'(0));
		wcol_next = dq_q + CW'(rnz);
	end

	// window accumulation
	logic [CW-1:0]         wstart_q, wcol_q, span;
	logic [TW-1:0]         j_q, last_j;
	logic signed [CSW-1:0] cr_acc_q, ci_acc_q;
	logic [PSW-1:0]        pa_acc_q, pb_acc_q;
	col_sums_t             tap;
	logic [OW-1:0]         cr_mag, ci_mag;
	logic                  win_last;

	always_comb begin
		span     = col_q - wstart_q;
		last_j   = span[TW-1:0];
		tap      = taps_q[j_q];
		cr_mag   = OW'(cr_acc_q[CSW-1] ? -cr_acc_q : cr_acc_q);
		ci_mag   = OW'(ci_acc_q[CSW-1] ? -ci_acc_q : ci_acc_q);
		win_last = ({1'b0, wstart_q} + NW'(st)) > {1'b0, col_q};
	end

	logic                coh_done;
	logic [COH_BITS-1:0] coh_val;

	icw_coh #(
		.OW(OW)
	) u_coh (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_START),
		.cr_mag(cr_mag),
		.ci_mag(ci_mag),
		.pa    (OW'(pa_acc_q)),
		.pb    (OW'(pb_acc_q)),
		.done  (coh_done),
		.coh   (coh_val)
	);

	logic out_load, out_valid_q;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign out_ch.valid = out_valid_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q   <= ({1'b0, c_now} + NW'(1) == ns) ? '0 : c_now + CW'(1);
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_UPD;
				ST_UPD:  state_q <= (is_end || is_mid) ? ST_DIV : ST_IDLE;
				ST_DIV: begin
					if (dcnt_q == DCW'(CW)) begin
						if ((mid_q && rnz) || (s_next > {1'b0, col_q})) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (j_q == last_j) begin
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_COH;
				ST_COH: begin
					if (coh_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= (end_q && !win_last) ? ST_SUM : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ar_q    <= in_ch.a_re;
			ai_q    <= in_ch.a_im;
			br_q    <= in_ch.b_re;
			bi_q    <= in_ch.b_im;
			first_q <= in_ch.first_row;
			last_q  <= in_ch.last_row;
			col_q   <= c_now;
		end
		if (state_q == ST_PROD) begin
			xr_q <= PRB'(p_rr) + PRB'(p_ii);
			xi_q <= PRB'(p_ir) - PRB'(p_ri);
			pa_q <= PRB'(unsigned'(p_aa));
			pb_q <= PRB'(unsigned'(p_bb));
		end
		if (state_q == ST_UPD) begin
			taps_q[0] <= upd;
			for (int i = 1; i < MAX_WIN_COLS; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			end_q  <= is_end;
			mid_q  <= is_mid;
			v_q    <= is_end ? v_end : v_mid;
			dq_q   <= is_end ? v_end : v_mid;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (dcnt_q != DCW'(CW)) begin
				dq_q   <= {dq_q[CW-2:0], ge};
				rem_q  <= ge ? WW'(r2 - {1'b0, st}) : r2[WW-1:0];
				dcnt_q <= dcnt_q + DCW'(1);
			end else begin
				wstart_q <= s_next[CW-1:0];
				wcol_q   <= wcol_next;
				j_q      <= '0;
				cr_acc_q <= '0;
				ci_acc_q <= '0;
				pa_acc_q <= '0;
				pb_acc_q <= '0;
			end
		end
		if (state_q == ST_SUM) begin
			cr_acc_q <= cr_acc_q + CSW'($signed(tap.cross_re));
			ci_acc_q <= ci_acc_q + CSW'($signed(tap.cross_im));
			pa_acc_q <= pa_acc_q + PSW'(tap.pow_a);
			pb_acc_q <= pb_acc_q + PSW'(tap.pow_b);
			j_q      <= j_q + TW'(1);
		end
		if (out_load) begin
			out_ch.coherence <= coh_val;
			out_ch.out_col   <= COL_OUT_BITS'(wcol_q);
			out_ch.hist_bin  <= hist_of(coh_val);
			out_ch.line_done <= end_q && win_last;
			// advance to the next window of the line end
			wstart_q <= wstart_q + CW'(st);
			wcol_q   <= wcol_q + CW'(1);
			j_q      <= '0;
			cr_acc_q <= '0;
			ci_acc_q <= '0;
			pa_acc_q <= '0;
			pb_acc_q <= '0;
		end
	end
endmodule

/* hw/rtl/icw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module icw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/icw_coh.sv */
// Coherence unit: squares and power product on a shared half-width multiplier,
// then a bit-serial root search for floor(2^15 * |C| / sqrt(Pa*Pb)). Uses icw_pkg.
module icw_coh #(
	parameter int OW = 43
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [OW-1:0]                 cr_mag,
	input  logic [OW-1:0]                 ci_mag,
	input  logic [OW-1:0]                 pa,
	input  logic [OW-1:0]                 pb,
	output logic                          done,
	output logic [icw_pkg::COH_BITS-1:0]  coh
);
	import icw_pkg::*;

	localparam int H          = (OW + 1) / 2;
	localparam int AW2        = 2 * H;
	localparam int PW         = 4 * H + 1;
	localparam int ROOT_SHIFT = 2 * (COH_BITS - 1);
	localparam int RW         = 4 * H + 2 * COH_BITS + 1;
	localparam logic [3:0] LAST_STEP = 4'd11;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_MUL  = 4'b0010,
		C_CHK  = 4'b0100,
		C_ROOT = 4'b1000
	} coh_state_t;

	coh_state_t          state_q;
	logic [AW2-1:0]      ca_q, ci_q, pa_q, pb_q;
	logic [3:0]          step_q;
	logic [PW-1:0]       num_q, den_q;
	logic [RW-1:0]       dr2_q, x_q, y_q, n_q;
	logic [COH_BITS-1:0] r_q, bit_q;

	logic [AW2-1:0]   op_a, op_b;
	logic [H-1:0]     ah, bh;
	logic [2*H-1:0]   pp;
	logic [PW-1:0]    pp_sh;
	logic [RW-1:0]    cand, x_n;
	logic             fits;
	logic [COH_BITS-1:0] r_fin;

	always_comb begin
		unique case (step_q[3:2])
			2'd0:    begin op_a = ca_q; op_b = ca_q; end
			2'd1:    begin op_a = ci_q; op_b = ci_q; end
			default: begin op_a = pa_q; op_b = pb_q; end
		endcase
		ah = step_q[1] ? op_a[AW2-1:H] : op_a[H-1:0];
		bh = step_q[0] ? op_b[AW2-1:H] : op_b[H-1:0];
		pp = ah * bh;
		unique case (step_q[1:0])
			2'd0:    pp_sh = PW'(pp);
			2'd3:    pp_sh = PW'(pp) << (2 * H);
			default: pp_sh = PW'(pp) << H;
		endcase
		// test one more result bit: D*(r+b)^2 = D*r^2 + (D*r << k+1) + (D << 2k)
		cand  = dr2_q + x_q + y_q;
		fits  = cand <= n_q;
		x_n   = fits ? x_q + (y_q << 1) : x_q;
		r_fin = fits ? (r_q | bit_q) : r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done    <= 1'b0;
			coh     <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					if (step_q == LAST_STEP) begin
						state_q <= C_CHK;
					end
				end
				C_CHK: begin
					if (den_q == '0) begin
						coh     <= '0;
						done    <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						state_q <= C_ROOT;
					end
				end
				C_ROOT: begin
					if (bit_q[0]) begin
						coh     <= (r_fin > COH_BITS'(ONE_Q15)) ? COH_BITS'(ONE_Q15) : r_fin;
						done    <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				ca_q   <= AW2'(cr_mag);
				ci_q   <= AW2'(ci_mag);
				pa_q   <= AW2'(pa);
				pb_q   <= AW2'(pb);
				step_q <= '0;
				num_q  <= '0;
				den_q  <= '0;
			end
			C_MUL: begin
				step_q <= step_q + 4'd1;
				if (step_q[3]) begin
					den_q <= den_q + pp_sh;
				end else begin
					num_q <= num_q + pp_sh;
				end
			end
			C_CHK: begin
				dr2_q <= '0;
				x_q   <= '0;
				y_q   <= RW'(den_q) << ROOT_SHIFT;
				n_q   <= RW'(num_q) << ROOT_SHIFT;
				r_q   <= '0;
				bit_q <= COH_BITS'(1) << (COH_BITS - 1);
			end
			C_ROOT: begin
				if (fits) begin
					dr2_q <= cand;
				end
				r_q   <= r_fin;
				x_q   <= x_n >> 1;
				y_q   <= y_q >> 2;
				bit_q <= bit_q >> 1;
			end
			default: ;
		endcase
	end
endmodule
